FILE: hw/rtl/rtlu_pkg.sv
// rtlu_pkg: shared types, codes and helpers for the recent tag list unit
// no dependencies; imported by rtlu_ctrl, rtlu_datapath and recent_tag_list_unit
`timescale 1ns / 1ps

package rtlu_pkg;

    localparam int unsigned LIST_DEPTH_DEF = 16;
    localparam int unsigned ID_BYTES_DEF   = 8;

    // operation codes
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DEL_POS = 3'd1;
    localparam logic [2:0] OP_DEL_KEY = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    localparam logic [4:0] COUNT_MAX = 5'd31;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  position;
        logic [63:0] tag_id;
        logic [63:0] date_stamp;
        logic        error_mark;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic [63:0] read_tag_id;
        logic [63:0] read_date_stamp;
        logic        read_error_mark;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } ctrl_cmd_t;

    // cut an id to nbytes bytes and clear everything from the first zero byte on
    function automatic logic [63:0] norm_id(input logic [63:0] v, input int unsigned nbytes);
        logic [63:0] r;
        logic        run;
        r   = '0;
        run = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= nbytes || v[8*b +: 8] == 8'h00) begin
                run = 1'b0;
            end
            if (run) begin
                r[8*b +: 8] = v[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/rtlu_ctrl.sv
// rtlu_ctrl: sequencer for the recent tag list unit
// depends on rtlu_pkg; drives the command struct of rtlu_datapath
`timescale 1ns / 1ps

module rtlu_ctrl
    import rtlu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = req_valid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready  = 1'b0;
        cmd.exec   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = out_free;
                req_ready  = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        cmd.load = req_valid && req_ready;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: hw/rtl/rtlu_datapath.sv
// rtlu_datapath: slot registers, shift network, key match, count and response register
// depends on rtlu_pkg; commanded by rtlu_ctrl
`timescale 1ns / 1ps

module rtlu_datapath
    import rtlu_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int unsigned ID_BYTES   = ID_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    input  req_t      req,
    output rsp_t      rsp
);

    localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

    // latched request, id already normalized
    req_t  req_norm;
    req_t  req_reg;
    logic  [1:0] status_reg;
    logic  [1:0] status_next;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;

    logic [63:0] id_store_reg   [LIST_DEPTH];
    logic [63:0] id_store_next  [LIST_DEPTH];
    logic [63:0] date_store_reg [LIST_DEPTH];
    logic [63:0] date_store_next[LIST_DEPTH];
    logic        mark_store_reg [LIST_DEPTH];
    logic        mark_store_next[LIST_DEPTH];

    logic                  pos_ok;
    logic                  needs_pos;
    logic [IDX_W-1:0]      pos_idx;
    logic [LIST_DEPTH-1:0] hit;
    logic [LIST_DEPTH-1:0] del_mask;
    logic [LIST_DEPTH-1:0] filled;
    logic [LIST_DEPTH-1:0] lead;
    logic [CNT_W-1:0]      count;
    logic                  do_ins;
    logic                  do_del;

    assign pos_ok    = (32'(req_reg.position) < LIST_DEPTH);
    assign needs_pos = (req_reg.op == OP_INSERT) || (req_reg.op == OP_DEL_POS)
                    || (req_reg.op == OP_READ);
    assign pos_idx   = IDX_W'(req_reg.position);

    // incoming request with its id cut to length
    always_comb
    begin
        req_norm        = req;
        req_norm.tag_id = norm_id(req.tag_id, ID_BYTES);
    end

    // per-slot key compare and the "at or after" masks
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            hit[i] = (id_store_reg[i] == req_reg.tag_id);
        end
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (req_reg.op == OP_DEL_KEY)
            begin
                del_mask[i] = |(hit & ({LIST_DEPTH{1'b1}} >> (LIST_DEPTH - 1 - i)));
            end
            else
            begin
                del_mask[i] = (32'(i) >= 32'(req_reg.position));
            end
        end
    end

    always_comb
    begin
        do_ins = cmd.exec && pos_ok && (req_reg.op == OP_INSERT);
        do_del = cmd.exec && (((req_reg.op == OP_DEL_POS) && pos_ok)
                           || ((req_reg.op == OP_DEL_KEY) && (|hit)));
        status_next = status_reg;
        if (cmd.exec)
        begin
            status_next = ST_OK;
            if (needs_pos && !pos_ok)
            begin
                status_next = ST_RANGE;
            end
            else if ((req_reg.op == OP_DEL_KEY) && !(|hit))
            begin
                status_next = ST_NOT_FOUND;
            end
        end
    end

    // shift network
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            id_store_next[i]   = id_store_reg[i];
            date_store_next[i] = date_store_reg[i];
            mark_store_next[i] = mark_store_reg[i];
            if (cmd.exec && (req_reg.op == OP_CLEAR))
            begin
                id_store_next[i]   = '0;
                date_store_next[i] = '0;
                mark_store_next[i] = 1'b0;
            end
            else if (do_ins)
            begin
                if (32'(i) == 32'(req_reg.position))
                begin
                    id_store_next[i]   = req_reg.tag_id;
                    date_store_next[i] = req_reg.date_stamp;
                    mark_store_next[i] = req_reg.error_mark;
                end
                else if ((32'(i) > 32'(req_reg.position)) && (i > 0))
                begin
                    id_store_next[i]   = id_store_reg[i-1];
                    date_store_next[i] = date_store_reg[i-1];
                    mark_store_next[i] = mark_store_reg[i-1];
                end
            end
            else if (do_del && del_mask[i])
            begin
                if (i == LIST_DEPTH - 1)
                begin
                    id_store_next[i]   = '0;
                    date_store_next[i] = '0;
                    mark_store_next[i] = 1'b0;
                end
                else
                begin
                    id_store_next[i]   = id_store_reg[i+1];
                    date_store_next[i] = date_store_reg[i+1];
                    mark_store_next[i] = mark_store_reg[i+1];
                end
            end
        end
    end

    // leading count: thermometer of filled slots, then encode its edge
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            filled[i] = |id_store_reg[i];
        end
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            lead[i] = &(filled | ~({LIST_DEPTH{1'b1}} >> (LIST_DEPTH - 1 - i)));
        end
        count = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (lead[i] && ((i == LIST_DEPTH - 1) || !lead[(i + 1) % LIST_DEPTH]))
            begin
                count = count | CNT_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        rsp_next                 = rsp_reg;
        if (cmd.finish)
        begin
            rsp_next.status          = status_reg;
            rsp_next.entry_count     = (32'(count) > 32'(COUNT_MAX)) ? COUNT_MAX : 5'(count);
            rsp_next.read_tag_id     = '0;
            rsp_next.read_date_stamp = '0;
            rsp_next.read_error_mark = 1'b0;
            if ((req_reg.op == OP_READ) && pos_ok)
            begin
                rsp_next.read_tag_id     = id_store_reg[pos_idx];
                rsp_next.read_date_stamp = date_store_reg[pos_idx];
                rsp_next.read_error_mark = mark_store_reg[pos_idx];
            end
        end
    end

    assign rsp = rsp_reg;

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_norm;
        end
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    // list slots, empty after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                id_store_reg[i]   <= '0;
                date_store_reg[i] <= '0;
                mark_store_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                id_store_reg[i]   <= id_store_next[i];
                date_store_reg[i] <= date_store_next[i];
                mark_store_reg[i] <= mark_store_next[i];
            end
        end
    end

endmodule

FILE: hw/rtl/recent_tag_list_unit.sv
// recent_tag_list_unit: top level of the ordered recent tag list
// depends on rtlu_pkg, rtlu_ctrl and rtlu_datapath
//
//   channel    handshake              payload   direction
//   request    req_valid / req_ready  req_t     in
//   response   rsp_valid / rsp_ready  rsp_t     out
//
// each request passes the edit state, applying the edit to the slot registers
// (insert shift, delete shift, clear), then finish: entry count and read data
// a new request is taken in the finish cycle while the response register is free
// a response waiting on rsp_ready holds the next request off after its edit cycle
// reset clears every slot at once; no clearing pass is needed
`timescale 1ns / 1ps

module recent_tag_list_unit
    import rtlu_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int unsigned ID_BYTES   = ID_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    // request channel
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    // response channel
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    ctrl_cmd_t cmd;

    // sequencer: idle, edit, finish
    rtlu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    // slot registers with shift network and response register
    rtlu_datapath #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BYTES   (ID_BYTES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
